FILE: src/four_class_priority_fifo_scheduler_defines.svh
// assertion macros for the four-class priority fifo scheduler
`ifndef FOUR_CLASS_PRIORITY_FIFO_SCHEDULER_DEFINES_SVH
`define FOUR_CLASS_PRIORITY_FIFO_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FCPFS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// next-cycle implication, disabled during reset
`define FCPFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

FILE: src/fcpfs_pkg.sv
// shared types and constants of the four-class priority fifo scheduler
package fcpfs_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int CLASS_W     = 2;
   localparam int TAG_W       = 16;
   localparam int AGE_W       = 7;
   localparam int ENTRY_W     = TAG_W + AGE_W + 1;

   localparam logic [AGE_W-1:0] THRESHOLD_RESET = 7'd60;

   // request codes
   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   // class codes, lower code is served first
   localparam logic [CLASS_W-1:0] CLASS_OLD_FLAG    = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_YOUNG_FLAG  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_OLD_PLAIN   = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_YOUNG_PLAIN = 2'd3;

   // entry ram strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctrl_type;

endpackage

FILE: src/fcpfs_entry_ram.sv
// entry storage ram, one write port and one registered read port
module fcpfs_entry_ram
   import fcpfs_pkg::*;
#(
   parameter int ADDR_W = 6
) (
   input  logic               clock,
   input  ram_ctrl_type       ram_ctrl,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ram_ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fcpfs_class_ctrl.sv
// per-class head, tail and count registers, class pick and priority select
module fcpfs_class_ctrl
   import fcpfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int PTR_W       = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enq_fire,
   input  logic                     deq_fire,
   input  logic [AGE_W-1:0]         item_age,
   input  logic                     item_flag,
   input  logic [AGE_W-1:0]         threshold,
   output ram_ctrl_type             ram_ctrl,
   output logic [CLASS_W+PTR_W-1:0] wr_addr,
   output logic [CLASS_W+PTR_W-1:0] rd_addr,
   output logic                     deq_empty
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [PTR_W-1:0] head_ff  [NUM_CLASSES];
   logic [PTR_W-1:0] head_in  [NUM_CLASSES];
   logic [PTR_W-1:0] tail_ff  [NUM_CLASSES];
   logic [PTR_W-1:0] tail_in  [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];
   logic [CNT_W-1:0] count_in [NUM_CLASSES];

   logic [NUM_CLASSES-1:0] full;
   logic [NUM_CLASSES-1:0] busy;
   logic [CLASS_W-1:0]     enq_cls;
   logic [CLASS_W-1:0]     deq_cls;
   logic                   enq_ok;
   logic                   deq_ok;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
      logic [PTR_W-1:0] nxt;
      if (slot == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + PTR_W'(1);
      end
      return nxt;
   endfunction

   // class pick by age and flag
   always_comb begin
      if (item_age >= threshold) begin
         enq_cls = item_flag ? CLASS_OLD_FLAG : CLASS_OLD_PLAIN;
      end else begin
         enq_cls = item_flag ? CLASS_YOUNG_FLAG : CLASS_YOUNG_PLAIN;
      end
   end

   for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_status
      assign full[c] = (count_ff[c] == CNT_W'(QUEUE_DEPTH));
      assign busy[c] = (count_ff[c] != '0);
   end

   // lowest non-empty class wins
   always_comb begin
      deq_cls = '0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (busy[c]) begin
            deq_cls = CLASS_W'(c);
         end
      end
   end

   assign enq_ok    = enq_fire & ~full[enq_cls];
   assign deq_ok    = deq_fire & (|busy);
   assign deq_empty = ~(|busy);

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         head_in[c]  = head_ff[c];
         tail_in[c]  = tail_ff[c];
         count_in[c] = count_ff[c];
         if (enq_ok && (enq_cls == CLASS_W'(c))) begin
            tail_in[c]  = next_slot(tail_ff[c]);
            count_in[c] = count_ff[c] + CNT_W'(1);
         end
         if (deq_ok && (deq_cls == CLASS_W'(c))) begin
            head_in[c]  = next_slot(head_ff[c]);
            count_in[c] = count_ff[c] - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= head_in[c];
            tail_ff[c]  <= tail_in[c];
            count_ff[c] <= count_in[c];
         end
      end
   end

   assign ram_ctrl.wr_en = enq_ok;
   assign ram_ctrl.rd_en = deq_ok;
   assign wr_addr        = {enq_cls, tail_ff[enq_cls]};
   assign rd_addr        = {deq_cls, head_ff[deq_cls]};

endmodule

FILE: src/four_class_priority_fifo_scheduler.sv
// top level of the four-class strict-priority fifo scheduler
//
//   channel | ports                                   | direction | handshake
//   --------+-----------------------------------------+-----------+----------------
//   req     | mode, item_tag, item_age, item_flag     | in        | valid / stall
//   rsp     | all_empty, out_tag, out_age, out_flag   | out       | valid / stall
//   csr     | data (age threshold)                    | in        | valid / ready
//
// one transaction per cycle on req unless req stalls; a dequeue shows its result in the
// cycle after acceptance, set by the registered read port of the entry ram
// an enqueue gives no result; enqueue and dequeue never share a cycle
// reset clears heads, tails and counts in flip-flops at once, no clearing pass
// req stalls only while a result waits in the output register under rsp stall
module four_class_priority_fifo_scheduler
   import fcpfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_mode,
   input  logic [TAG_W-1:0] req_item_tag,
   input  logic [AGE_W-1:0] req_item_age,
   input  logic             req_item_priority_flag,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_all_empty,
   output logic [TAG_W-1:0] rsp_out_tag,
   output logic [AGE_W-1:0] rsp_out_age,
   output logic             rsp_out_priority_flag,
   // threshold register write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [AGE_W-1:0] csr_data
);

   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W = CLASS_W + PTR_W;

   logic [AGE_W-1:0]   threshold_ff;
   logic [AGE_W-1:0]   threshold_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_empty_ff;
   logic               rsp_empty_in;

   logic               req_fire;
   logic               enq_fire;
   logic               deq_fire;
   logic               deq_empty;
   ram_ctrl_type       ram_ctrl;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;

   // the output register is free unless a result is held under stall
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign enq_fire  = req_fire & (req_mode == MODE_ENQ);
   assign deq_fire  = req_fire & (req_mode == MODE_DEQ);

   // packed entry: tag, age, flag
   assign wr_data = {req_item_tag, req_item_age, req_item_priority_flag};

   // threshold register, always ready
   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_data : threshold_ff;

   // result register: a new result loads on a dequeue, otherwise
   // the held one drains when the consumer takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_empty_in = rsp_empty_ff;
      if (deq_fire) begin
         rsp_valid_in = 1'b1;
         rsp_empty_in = deq_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_empty_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_empty_ff <= rsp_empty_in;
      end
   end

   fcpfs_class_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PTR_W       (PTR_W)
   ) u_class_ctrl (
      .clock     (clock),
      .reset     (reset),
      .enq_fire  (enq_fire),
      .deq_fire  (deq_fire),
      .item_age  (req_item_age),
      .item_flag (req_item_priority_flag),
      .threshold (threshold_ff),
      .ram_ctrl  (ram_ctrl),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .deq_empty (deq_empty)
   );

   // read data stays put until the next dequeue, which only happens once
   // the held result has been taken
   fcpfs_entry_ram #(
      .ADDR_W (ADDR_W)
   ) u_entry_ram (
      .clock    (clock),
      .ram_ctrl (ram_ctrl),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   // empty result forces the payload to zero
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_all_empty         = rsp_empty_ff;
   assign rsp_out_tag           = rsp_empty_ff ? '0 : rd_data[ENTRY_W-1 -: TAG_W];
   assign rsp_out_age           = rsp_empty_ff ? '0 : rd_data[AGE_W:1];
   assign rsp_out_priority_flag = rsp_empty_ff ? 1'b0 : rd_data[0];

endmodule

FILE: src/fcpfs_checker.sv
// port-level checks of the scheduler and their bind
`include "four_class_priority_fifo_scheduler_defines.svh"

module fcpfs_checker
   import fcpfs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             req_mode,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_all_empty,
   input logic [TAG_W-1:0] rsp_out_tag,
   input logic [AGE_W-1:0] rsp_out_age,
   input logic             rsp_out_priority_flag
);

   logic               req_take;
   logic               rsp_held;
   logic               rsp_zero;
   logic [ENTRY_W:0]   rsp_payload;

   assign req_take    = req_valid && !req_stall;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_zero    = (rsp_out_tag == '0) && (rsp_out_age == '0) && !rsp_out_priority_flag;
   assign rsp_payload = {rsp_all_empty, rsp_out_tag, rsp_out_age, rsp_out_priority_flag};

   // stalled result holds
   `FCPFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload))

   // empty report carries a zero payload
   `FCPFS_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && rsp_all_empty, rsp_zero)

   // request side only stalls behind a held result
   `FCPFS_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_held)

   // every accepted dequeue gives a result in the next cycle
   `FCPFS_ASSERT_NEXT(a_deq_result, clock, reset, req_take && req_mode == MODE_DEQ, rsp_valid)

   // an enqueue on a free output gives no result
   `FCPFS_ASSERT_NEXT(a_enq_silent, clock, reset, req_take && req_mode == MODE_ENQ, !rsp_valid)

endmodule

bind four_class_priority_fifo_scheduler fcpfs_checker u_fcpfs_checker (.*);

FILE: dv/fcpfs_sched_checker.sv
// checker for the four-class priority fifo scheduler: predicts served items and compares rsp
module fcpfs_sched_checker
   import fcpfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic             req_mode,
   input  logic [TAG_W-1:0] req_item_tag,
   input  logic [AGE_W-1:0] req_item_age,
   input  logic             req_item_priority_flag,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic             rsp_all_empty,
   input  logic [TAG_W-1:0] rsp_out_tag,
   input  logic [AGE_W-1:0] rsp_out_age,
   input  logic             rsp_out_priority_flag,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [AGE_W-1:0] csr_data,
   output int               error_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
      logic             flag;
   } held_item_t;

   typedef struct packed {
      logic             all_empty;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
      logic             flag;
   } served_item_t;

   held_item_t       class_fifo[NUM_CLASSES][$];
   served_item_t     served_q[$];
   logic [AGE_W-1:0] age_threshold;
   int               mismatches = 0;

   function automatic logic [CLASS_W-1:0] class_for(input logic [AGE_W-1:0] age,
                                                   input logic flag);
      if (age >= age_threshold) return flag ? CLASS_OLD_FLAG : CLASS_OLD_PLAIN;
      return flag ? CLASS_YOUNG_FLAG : CLASS_YOUNG_PLAIN;
   endfunction

   // enqueue into its class unless full; dequeue serves the lowest non-empty class
   function automatic void take_request(input logic mode, input held_item_t item);
      logic [CLASS_W-1:0] cls;
      served_item_t       reply;
      held_item_t         head;
      bit                 found;
      if (mode == MODE_ENQ) begin
         cls = class_for(item.age, item.flag);
         if (class_fifo[cls].size() < QUEUE_DEPTH) class_fifo[cls].push_back(item);
         return;
      end
      found = 1'b0;
      reply = '0;
      reply.all_empty = 1'b1;
      for (int c = 0; c < NUM_CLASSES && !found; c++) begin
         if (class_fifo[c].size() != 0) begin
            head  = class_fifo[c].pop_front();
            reply = {1'b0, head};
            found = 1'b1;
         end
      end
      served_q.push_back(reply);
   endfunction

   function automatic void check_reply(input served_item_t got);
      served_item_t want;
      if (served_q.size() == 0) begin
         $error("rsp transaction with no dequeue outstanding, tag %0h", got.tag);
         mismatches++;
         return;
      end
      want = served_q.pop_front();
      if (got.all_empty !== want.all_empty) begin
         $error("all_empty: expected %0b, actual %0b", want.all_empty, got.all_empty);
         mismatches++;
      end
      if (got.tag !== want.tag) begin
         $error("out_tag: expected %0h, actual %0h", want.tag, got.tag);
         mismatches++;
      end
      if (got.age !== want.age) begin
         $error("out_age: expected %0d, actual %0d", want.age, got.age);
         mismatches++;
      end
      if (got.flag !== want.flag) begin
         $error("out_priority_flag: expected %0b, actual %0b", want.flag, got.flag);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) class_fifo[c].delete();
         served_q.delete();
         age_threshold = THRESHOLD_RESET;
      end else begin
         if (csr_valid && csr_ready) age_threshold = csr_data;
         if (req_valid && !req_stall)
            take_request(req_mode, {req_item_tag, req_item_age, req_item_priority_flag});
         if (rsp_valid && !rsp_stall)
            check_reply({rsp_all_empty, rsp_out_tag, rsp_out_age, rsp_out_priority_flag});
      end
      error_count   <= mismatches;
      pending_count <= served_q.size();
   end

endmodule

FILE: dv/tb_top.sv
// testbench top for the four-class priority fifo scheduler: stimulus, idling and verdict
module tb_top
   import fcpfs_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 16;
   localparam int LONG_HOLD   = 60;   // long enough to fill the output register and stall req
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 88;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_mode = MODE_ENQ;
   logic [TAG_W-1:0] req_item_tag = '0;
   logic [AGE_W-1:0] req_item_age = '0;
   logic             req_item_priority_flag = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_all_empty;
   logic [TAG_W-1:0] rsp_out_tag;
   logic [AGE_W-1:0] rsp_out_age;
   logic             rsp_out_priority_flag;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [AGE_W-1:0] csr_data = '0;

   int               error_count;
   int               pending_count;

   // idling knobs, percent of cycles
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   // long hold-off handshake between the stimulus and the receiver process
   int               hold_requests = 0;
   int               holds_started = 0;
   int               hold_left = 0;
   // threshold the stimulus aims its ages at
   logic [AGE_W-1:0] cur_threshold = THRESHOLD_RESET;

   always #4 clock = ~clock;

   four_class_priority_fifo_scheduler #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_mode               (req_mode),
      .req_item_tag           (req_item_tag),
      .req_item_age           (req_item_age),
      .req_item_priority_flag (req_item_priority_flag),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_all_empty          (rsp_all_empty),
      .rsp_out_tag            (rsp_out_tag),
      .rsp_out_age            (rsp_out_age),
      .rsp_out_priority_flag  (rsp_out_priority_flag),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_data               (csr_data)
   );

   fcpfs_sched_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_sched_checker (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_mode               (req_mode),
      .req_item_tag           (req_item_tag),
      .req_item_age           (req_item_age),
      .req_item_priority_flag (req_item_priority_flag),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_all_empty          (rsp_all_empty),
      .rsp_out_tag            (rsp_out_tag),
      .rsp_out_age            (rsp_out_age),
      .rsp_out_priority_flag  (rsp_out_priority_flag),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_data               (csr_data),
      .error_count            (error_count),
      .pending_count          (pending_count)
   );

   // receiver: random stall at stall_pct, or a long hold-off counted here when one is asked
   always @(posedge clock) begin
      if (hold_requests != holds_started) begin
         holds_started = hold_requests;
         hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // offer one transaction, hold it until accepted, then maybe go idle for a while
   task automatic send_request(input logic mode, input logic [TAG_W-1:0] tag,
                               input logic [AGE_W-1:0] age, input logic flag);
      req_valid              <= 1'b1;
      req_mode               <= mode;
      req_item_tag           <= tag;
      req_item_age           <= age;
      req_item_priority_flag <= flag;
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // threshold write only once the block is idle: every result back, last enqueue settled
   task automatic write_threshold(input logic [AGE_W-1:0] value);
      do @(posedge clock); while (pending_count != 0);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      cur_threshold  = value;
   endtask

   // ages aimed at old or young, often right on the threshold boundary
   function automatic logic [AGE_W-1:0] pick_age(input bit want_old);
      bit on_edge;
      on_edge = ($urandom_range(2) == 0);
      if (want_old)
         return on_edge ? cur_threshold : AGE_W'($urandom_range(127, cur_threshold));
      if (cur_threshold == 0) return AGE_W'($urandom_range(127));
      return on_edge ? cur_threshold - AGE_W'(1) : AGE_W'($urandom_range(cur_threshold - 1, 0));
   endfunction

   // random traffic in bursts: fill bursts aimed at one class so classes run full,
   // drain bursts that run classes empty, and mixed noise
   task automatic run_traffic(input int count);
      int   left;
      int   kind;
      int   len;
      bit   burst_old;
      bit   burst_flag;
      logic mode;
      bit   old_pick;
      bit   flag_pick;
      left = count;
      while (left > 0) begin
         kind       = $urandom_range(9);
         len        = $urandom_range(20, 1);
         burst_old  = 1'($urandom_range(1));
         burst_flag = 1'($urandom_range(1));
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            if (kind < 4) begin
               mode = MODE_ENQ;
            end else if (kind < 7) begin
               mode = MODE_DEQ;
            end else begin
               mode = $urandom_range(1) ? MODE_DEQ : MODE_ENQ;
            end
            // mostly stay on the burst's class, sometimes stray
            old_pick  = ($urandom_range(3) == 0) ? 1'($urandom_range(1)) : burst_old;
            flag_pick = ($urandom_range(3) == 0) ? 1'($urandom_range(1)) : burst_flag;
            send_request(mode, TAG_W'($urandom), pick_age(old_pick), flag_pick);
         end
         left -= len;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset threshold of 60
      // dequeue with every class empty
      send_request(MODE_DEQ, 16'hFFFF, 7'h7F, 1'b1);
      // one item into each class, extremes of tag and age
      send_request(MODE_ENQ, 16'h0000, 7'd0, 1'b1);     // young with flag
      send_request(MODE_ENQ, 16'hFFFF, 7'd127, 1'b1);   // old with flag
      send_request(MODE_ENQ, 16'h5A5A, 7'd59, 1'b0);    // just below threshold
      send_request(MODE_ENQ, 16'hA5A5, 7'd60, 1'b0);    // exactly at threshold
      // served in strict class order, then empty again
      repeat (5) send_request(MODE_DEQ, 16'h0000, 7'd0, 1'b0);
      // fill the old plain class past its depth, the last enqueue is dropped
      for (int i = 0; i <= QUEUE_DEPTH; i++)
         send_request(MODE_ENQ, TAG_W'(i * 16'h1111 + 1), AGE_W'(60 + i * 4), 1'b0);
      send_request(MODE_DEQ, 16'h0000, 7'd0, 1'b0);

      // random phases, each with its own threshold and idling pattern
      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         stall_pct <= 0;
         if (p == 0) begin
            write_threshold(7'd127);
         end else if (p == 1) begin
            write_threshold(7'd0);
         end else begin
            write_threshold(AGE_W'($urandom_range(127)));
         end
         case (p % 4)
            0: begin
               send_idle_pct  = 0;
               stall_pct     <= 0;
            end
            1: begin
               send_idle_pct  = 67;
               stall_pct     <= 0;
            end
            2: begin
               send_idle_pct  = 0;
               stall_pct     <= 67;
            end
            default: begin
               send_idle_pct  = 38;
               stall_pct     <= 38;
            end
         endcase
         // back-pressure: receiver holds off while the sender keeps offering at full rate
         if (p == 4) hold_requests <= hold_requests + 1;
         run_traffic(PHASE_ITEMS);
      end

      // drain and let the last results settle
      req_valid <= 1'b0;
      stall_pct <= 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
